@@ design/gmid_pkg.sv @@
// ----------------------------------------------------------------------------
// gmid_pkg: shared types and constants for the periodic grid distance block
// Field widths, item structs, the square root chain state and the register
// index codes used by the front end, the root cells and the top level.
// ----------------------------------------------------------------------------
package gmid_pkg;

   // field and register widths
   localparam int COORD_W  = 10;
   localparam int CFG_W    = 11;
   localparam int SQ_W     = 20;
   localparam int Q8_W     = 18;
   localparam int FRAC_W   = 2 * Q8_W - SQ_W;     // fraction bits of the radicand
   localparam int RAD_W    = SQ_W + FRAC_W;       // radicand width
   localparam int REM_W    = Q8_W + 3;            // partial remainder width
   localparam int AXES     = 3;
   localparam int SQ_AX_W  = 2 * CFG_W - 1;       // one squared axis difference
   localparam int SUM_W    = SQ_AX_W + 2;         // sum over all axes
   localparam int CSR_IDX_W = 2;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] a_x;
      logic [COORD_W-1:0] a_y;
      logic [COORD_W-1:0] a_z;
      logic [COORD_W-1:0] b_x;
      logic [COORD_W-1:0] b_y;
      logic [COORD_W-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic [SQ_W-1:0] dist_squared;
      logic [Q8_W-1:0] distance_q8;
      logic            out_of_range;
   } rsp_type;

   // effective cell counts, index 0 is x
   typedef logic [AXES-1:0][CFG_W-1:0] cells_type;

   // state handed from one root cell to the next
   typedef struct packed {
      logic [SQ_W-1:0]  dist_squared;
      logic             out_of_range;
      logic [REM_W-1:0] rem;
      logic [Q8_W-1:0]  root;
   } sqrt_state_type;

endpackage

@@ design/periodic_grid_min_image_distance.sv @@
// ----------------------------------------------------------------------------
// periodic_grid_min_image_distance: minimum-image distance on a periodic grid
// Wraps each axis difference to the nearest image, sums the squares and
// takes the square root in Q10.8 through a chain of one-digit root cells.
//
//   channel   ports                          direction
//   req       req_valid/req_ready/req_data   in, one item of two cell positions
//   rsp       rsp_valid/rsp_ready/rsp_data   out, one item per request item
//   csr       csr_we/csr_index/csr_wdata     in, cell count writes
//
// One item a cycle while the result channel is ready; each item passes
// four front stages, then one root cell per root bit in the cell chain.
// Every stage stalls only when full and blocked, so bubbles close up.
// Reset empties the pipeline and sets the cell counts to 1024, 1024, 1.
// Cell counts are clamped to 1..MAX_CELLS when written.
// ----------------------------------------------------------------------------
module periodic_grid_min_image_distance
   import gmid_pkg::*;
#(
   parameter int MAX_CELLS = 1024,
   parameter int DIMS      = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   function automatic logic [CFG_W-1:0] clamp_cells(input logic [CFG_W-1:0] raw);
      logic [CFG_W-1:0] n;
      begin
         n = raw;
         if (n == '0) begin
            n = CFG_W'(1);
         end
         if (int'(n) > MAX_CELLS) begin
            n = CFG_W'(MAX_CELLS);
         end
         return n;
      end
   endfunction

   cells_type        cells_ff, cells_in;
   logic             chain_valid [Q8_W+1];
   logic             chain_ready [Q8_W+1];
   sqrt_state_type   chain_state [Q8_W+1];

   // take cell count writes, already clamped
   always_comb begin
      cells_in = cells_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CELLS_X: cells_in[0] = clamp_cells(csr_wdata);
            CSR_CELLS_Y: cells_in[1] = clamp_cells(csr_wdata);
            CSR_CELLS_Z: cells_in[2] = clamp_cells(csr_wdata);
            default:     cells_in    = cells_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff[0] <= clamp_cells(CFG_W'(1024));
         cells_ff[1] <= clamp_cells(CFG_W'(1024));
         cells_ff[2] <= clamp_cells(CFG_W'(1));
      end else begin
         cells_ff <= cells_in;
      end
   end

   // wrap, square and sum
   gmid_front #(
      .DIMS (DIMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_data),
      .cells     (cells_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_state (chain_state[0])
   );

   // one root bit per cell, most significant first
   genvar k;
   for (k = 0; k < Q8_W; k++) begin : g_cell
      gmid_sqrt_cell #(
         .STEP (Q8_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_state  (chain_state[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_state (chain_state[k+1])
      );
   end

   // last cell register drives the result
   assign rsp_valid               = chain_valid[Q8_W];
   assign chain_ready[Q8_W]       = rsp_ready;
   assign rsp_data.dist_squared   = chain_state[Q8_W].dist_squared;
   assign rsp_data.distance_q8    = chain_state[Q8_W].root;
   assign rsp_data.out_of_range   = chain_state[Q8_W].out_of_range;

`ifndef NO_ASSERTIONS
   // root is the floor: its square does not pass the radicand
   a_root_low : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (40'(rsp_data.distance_q8) * 40'(rsp_data.distance_q8)) <=
                    40'({rsp_data.dist_squared, {FRAC_W{1'b0}}}))
      else $error("root square exceeds radicand");

   // root is the floor: the next value squared passes the radicand
   a_root_high : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((40'(rsp_data.distance_q8) + 40'd1) *
                     (40'(rsp_data.distance_q8) + 40'd1)) >
                    40'({rsp_data.dist_squared, {FRAC_W{1'b0}}}))
      else $error("root below floor");

   // input stalls only when the whole chain is backed up at the output
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with room in pipeline");

   // pipeline is empty when reset is released
   a_reset_empty : assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result present after reset");
`endif

endmodule

@@ design/gmid_front.sv @@
// ----------------------------------------------------------------------------
// gmid_front: per-axis wrap, square and sum
// Four pipeline stages: absolute difference and range check, minimum-image
// wrap, square, then saturating sum that seeds the square root chain.
// ----------------------------------------------------------------------------
module gmid_front
   import gmid_pkg::*;
#(
   parameter int DIMS = 3
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  req_type        in_item,
   input  cells_type      cells,
   output logic           out_valid,
   input  logic           out_ready,
   output sqrt_state_type out_state
);

   logic [COORD_W-1:0] coord_a [AXES];
   logic [COORD_W-1:0] coord_b [AXES];
   logic [AXES-1:0]    oor_axis;

   logic               valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic               valid1_in, valid2_in, valid3_in, valid4_in;
   logic               rdy1, rdy2, rdy3, rdy4;

   logic [COORD_W-1:0] d1_ff  [AXES];
   logic [COORD_W-1:0] d1_in  [AXES];
   logic               oor1_ff, oor2_ff, oor3_ff;
   logic [CFG_W-1:0]   w2_ff  [AXES];
   logic [CFG_W-1:0]   w2_in  [AXES];
   logic [SQ_AX_W-1:0] sq3_ff [AXES];
   logic [SQ_AX_W-1:0] sq3_in [AXES];
   logic [SUM_W-1:0]   sum4;
   sqrt_state_type     state4_ff, state4_in;

   // unpack coordinates by axis
   always_comb begin
      coord_a[0] = in_item.a_x;
      coord_a[1] = in_item.a_y;
      coord_a[2] = in_item.a_z;
      coord_b[0] = in_item.b_x;
      coord_b[1] = in_item.b_y;
      coord_b[2] = in_item.b_z;
   end

   // stall chain: a stage loads when empty or when the next one moves
   assign rdy4     = !valid4_ff || out_ready;
   assign rdy3     = !valid3_ff || rdy4;
   assign rdy2     = !valid2_ff || rdy3;
   assign rdy1     = !valid1_ff || rdy2;
   assign in_ready = rdy1;

   assign valid1_in = rdy1 ? in_valid  : valid1_ff;
   assign valid2_in = rdy2 ? valid1_ff : valid2_ff;
   assign valid3_in = rdy3 ? valid2_ff : valid3_ff;
   assign valid4_in = rdy4 ? valid3_ff : valid4_ff;

   genvar ax;
   for (ax = 0; ax < AXES; ax++) begin : g_axis
      if (ax < DIMS) begin : g_used
         // absolute difference and range check
         always_comb begin
            d1_in[ax] = (coord_a[ax] > coord_b[ax]) ? coord_a[ax] - coord_b[ax]
                                                    : coord_b[ax] - coord_a[ax];
            oor_axis[ax] = ({1'b0, coord_a[ax]} >= cells[ax]) ||
                           ({1'b0, coord_b[ax]} >= cells[ax]);
         end
      end else begin : g_unused
         // drop axes beyond the grid dimension
         always_comb begin
            d1_in[ax]    = '0;
            oor_axis[ax] = 1'b0;
         end
      end

      // wrap when the difference passes half the cell count
      always_comb begin
         if (d1_ff[ax] > cells[ax][CFG_W-1:1]) begin
            if ({1'b0, d1_ff[ax]} > cells[ax]) begin
               w2_in[ax] = {1'b0, d1_ff[ax]} - cells[ax];
            end else begin
               w2_in[ax] = cells[ax] - {1'b0, d1_ff[ax]};
            end
         end else begin
            w2_in[ax] = {1'b0, d1_ff[ax]};
         end
      end

      // square the wrapped difference
      always_comb begin
         sq3_in[ax] = SQ_AX_W'(w2_ff[ax]) * SQ_AX_W'(w2_ff[ax]);
      end
   end

   // sum, saturate and seed the root chain
   always_comb begin
      sum4 = SUM_W'(sq3_ff[0]) + SUM_W'(sq3_ff[1]) + SUM_W'(sq3_ff[2]);
      state4_in.dist_squared = (|sum4[SUM_W-1:SQ_W]) ? {SQ_W{1'b1}} : sum4[SQ_W-1:0];
      state4_in.out_of_range = oor3_ff;
      state4_in.rem          = '0;
      state4_in.root         = '0;
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (rdy1) begin
         d1_ff   <= d1_in;
         oor1_ff <= |oor_axis;
      end
      if (rdy2) begin
         w2_ff   <= w2_in;
         oor2_ff <= oor1_ff;
      end
      if (rdy3) begin
         sq3_ff  <= sq3_in;
         oor3_ff <= oor2_ff;
      end
      if (rdy4) begin
         state4_ff <= state4_in;
      end
   end

   assign out_valid = valid4_ff;
   assign out_state = state4_ff;

endmodule

@@ design/gmid_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// gmid_sqrt_cell: one digit of the integer square root
// Brings in two radicand bits, tries the next root bit against the partial
// remainder and hands the updated state to the next cell.
// ----------------------------------------------------------------------------
module gmid_sqrt_cell
   import gmid_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  sqrt_state_type in_state,
   output logic           out_valid,
   input  logic           out_ready,
   output sqrt_state_type out_state
);

   logic             valid_ff, valid_in;
   sqrt_state_type   state_ff, state_in;
   logic [RAD_W-1:0] radicand;
   logic [1:0]       pair;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;

   // load when empty or when the next cell moves
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // try the next root bit
   always_comb begin
      radicand = {in_state.dist_squared, {FRAC_W{1'b0}}};
      pair     = radicand[2*STEP+1 -: 2];
      rem_sh   = {in_state.rem[REM_W-3:0], pair};
      trial    = {1'b0, in_state.root, 2'b01};
      state_in = in_state;
      if (rem_sh >= trial) begin
         state_in.rem  = rem_sh - trial;
         state_in.root = {in_state.root[Q8_W-2:0], 1'b1};
      end else begin
         state_in.rem  = rem_sh;
         state_in.root = {in_state.root[Q8_W-2:0], 1'b0};
      end
   end

   // hold valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (in_ready) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ tb/gmid_distance_monitor.sv @@
// ----------------------------------------------------------------------------
// gmid_distance_monitor: result prediction and checking for the grid distance
// Watches the request, result and register ports of the periodic grid
// distance block, tracks the cell counts, works out the wrapped squared
// distance, its Q10.8 root and the range flag for every accepted request
// item, and compares each accepted result item field by field in order.
// ----------------------------------------------------------------------------
module gmid_distance_monitor
   import gmid_pkg::*;
#(
   parameter int MAX_CELLS = 1024,
   parameter int DIMS      = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   error_count,
   output int                   outstanding
);

   localparam longint unsigned SQ_LIMIT = (64'd1 << SQ_W) - 1;

   // raw register values, index 0 is x
   logic [CFG_W-1:0] cell_count [AXES];
   rsp_type          expected_distances [$];
   int               mismatches = 0;

   // wrapped distance, root and flag for one pair of cell positions
   function automatic rsp_type predict_min_image(req_type item);
      logic [COORD_W-1:0] pa [AXES];
      logic [COORD_W-1:0] pb [AXES];
      int unsigned        n;
      int unsigned        d;
      int unsigned        half;
      longint unsigned    total;
      longint unsigned    radicand;
      longint unsigned    root;
      longint unsigned    trial;
      rsp_type            result;
      pa = '{item.a_x, item.a_y, item.a_z};
      pb = '{item.b_x, item.b_y, item.b_z};
      total = 0;
      result = '0;
      for (int axis = 0; axis < AXES; axis++) begin
         if (axis < DIMS) begin
            // clamp the count into 1..MAX_CELLS
            n = cell_count[axis];
            if (n == 0)
               n = 1;
            if (n > MAX_CELLS)
               n = MAX_CELLS;
            if (pa[axis] >= n || pb[axis] >= n)
               result.out_of_range = 1'b1;
            d = (pa[axis] > pb[axis]) ? pa[axis] - pb[axis] : pb[axis] - pa[axis];
            half = (n == 1) ? 0 : n / 2;
            // take the shorter way round the grid
            if (d > half)
               d = (d > n) ? d - n : n - d;
            total += longint'(d) * longint'(d);
         end
      end
      if (total > SQ_LIMIT)
         total = SQ_LIMIT;
      // bitwise integer root of the sum scaled by 2^16
      radicand = total << FRAC_W;
      root = 0;
      for (int b = Q8_W; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand)
            root = trial;
      end
      result.dist_squared = total[SQ_W-1:0];
      result.distance_q8  = root[Q8_W-1:0];
      return result;
   endfunction

   function automatic void note_mismatch(string field, longint unsigned want,
                                         longint unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cell_count[0] = 11'd1024;
         cell_count[1] = 11'd1024;
         cell_count[2] = 11'd1;
         expected_distances.delete();
      end else begin
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_CELLS_X: cell_count[0] = csr_wdata;
               CSR_CELLS_Y: cell_count[1] = csr_wdata;
               CSR_CELLS_Z: cell_count[2] = csr_wdata;
               default: ;
            endcase
         end
         // predict each accepted request item
         if (req_valid && req_ready)
            expected_distances.insert(expected_distances.size(),
                                      predict_min_image(req_data));
         // compare each accepted result item with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               mismatches++;
               $display("%0t: result item with none expected, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_distances.pop_front();
               if (rsp_data.dist_squared !== want.dist_squared)
                  note_mismatch("dist_squared", want.dist_squared, rsp_data.dist_squared);
               if (rsp_data.distance_q8 !== want.distance_q8)
                  note_mismatch("distance_q8", want.distance_q8, rsp_data.distance_q8);
               if (rsp_data.out_of_range !== want.out_of_range)
                  note_mismatch("out_of_range", want.out_of_range, rsp_data.out_of_range);
            end
         end
      end
      error_count <= mismatches;
      outstanding <= expected_distances.size();
   end

endmodule

@@ tb/tb_periodic_grid_min_image_distance.sv @@
// ----------------------------------------------------------------------------
// tb_periodic_grid_min_image_distance: stimulus and verdict for the grid block
// Runs directed pairs at the coordinate and cell count extremes, then random
// pairs under several cell count settings, with bursty requests and a
// stalling receiver. The distance monitor beside the block does the checking.
// ----------------------------------------------------------------------------
module tb_periodic_grid_min_image_distance;
   import gmid_pkg::*;

   localparam int MAX_CELLS   = 1024;
   localparam int DIMS        = 3;
   localparam int PHASE_ITEMS = 220;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CELLS_X;
   logic [CFG_W-1:0]     csr_wdata = '0;
   int                   error_count;
   int                   outstanding;

   // effective cell counts, used only to shape the stimulus
   int unsigned          grid_n [AXES] = '{1024, 1024, 1};
   int                   burst_left = 0;
   bit                   gaps_on = 1'b1;
   int unsigned          stall_tick = 0;
   stall_mode_type       stall_mode = STALL_NONE;

   always #2 clock = ~clock;

   periodic_grid_min_image_distance #(
      .MAX_CELLS (MAX_CELLS),
      .DIMS      (DIMS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gmid_distance_monitor #(
      .MAX_CELLS (MAX_CELLS),
      .DIMS      (DIMS)
   ) i_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // stall the result channel, switching among four randomly picked patterns
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_ready <= 1'b1;
         STALL_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         STALL_HEAVY:    rsp_ready <= ($urandom_range(0, 7) == 0);
         STALL_PERIODIC: rsp_ready <= (stall_tick[3:0] < 4'd11);
         default:        rsp_ready <= 1'b1;
      endcase
   end

   function automatic int unsigned effective_cells(logic [CFG_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > MAX_CELLS)
         return MAX_CELLS;
      return value;
   endfunction

   function automatic req_type point_pair(int ax, int ay, int az, int bx, int by, int bz);
      req_type item;
      item.a_x = COORD_W'(ax);
      item.a_y = COORD_W'(ay);
      item.a_z = COORD_W'(az);
      item.b_x = COORD_W'(bx);
      item.b_y = COORD_W'(by);
      item.b_z = COORD_W'(bz);
      return item;
   endfunction

   // write all three cell counts, x then y then z
   task automatic set_grid(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                           input logic [CFG_W-1:0] z);
      csr_we    <= 1'b1;
      csr_index <= CSR_CELLS_X;
      csr_wdata <= x;
      @(posedge clock);
      csr_index <= CSR_CELLS_Y;
      csr_wdata <= y;
      @(posedge clock);
      csr_index <= CSR_CELLS_Z;
      csr_wdata <= z;
      @(posedge clock);
      csr_we <= 1'b0;
      grid_n[0] = effective_cells(x);
      grid_n[1] = effective_cells(y);
      grid_n[2] = effective_cells(z);
   endtask

   // offer one item, opening a new burst after a random gap when due
   task automatic send_pair(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if (gaps_on)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // drop valid and wait until every expected result item is back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
      repeat (30) @(posedge clock);
   endtask

   // one axis: mostly in range, biased toward the wrap boundary
   task automatic pick_axis(input int unsigned n, output logic [COORD_W-1:0] a,
                            output logic [COORD_W-1:0] b);
      int unsigned half;
      int          s;
      half = n / 2;
      a = COORD_W'($urandom_range(0, n - 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: b = COORD_W'($urandom_range(0, n - 1));
         4, 5, 6: begin
            s = int'(a) + int'(half) + int'($urandom_range(0, 2)) - 1;
            if (s < 0)
               s += n;
            b = COORD_W'(s % n);
         end
         7: begin
            a = ($urandom_range(0, 1) == 1) ? COORD_W'(n - 1) : '0;
            b = ($urandom_range(0, 1) == 1) ? COORD_W'(n - 1) : '0;
         end
         8: begin
            a = COORD_W'($urandom_range(0, 1023));
            b = COORD_W'($urandom_range(0, 1023));
         end
         default: b = a;
      endcase
   endtask

   task automatic run_random(input int count);
      req_type item;
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (count) begin
         pick_axis(grid_n[0], item.a_x, item.b_x);
         pick_axis(grid_n[1], item.a_y, item.b_y);
         pick_axis(grid_n[2], item.a_z, item.b_z);
         send_pair(item);
      end
      drain_pipeline();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset counts: zero, wrap limits, exact half, z out of range
      send_pair(point_pair(0, 0, 0, 0, 0, 0));
      send_pair(point_pair(0, 0, 0, 1023, 1023, 0));
      send_pair(point_pair(0, 0, 0, 512, 0, 0));
      send_pair(point_pair(0, 0, 0, 513, 0, 0));
      send_pair(point_pair(1023, 1023, 1023, 1023, 1023, 1023));
      send_pair(point_pair(0, 0, 0, 0, 0, 1));
      send_pair(point_pair(100, 200, 0, 400, 600, 0));
      send_pair(point_pair(5, 1000, 0, 1018, 3, 0));
      send_pair(point_pair(511, 0, 0, 0, 511, 0));
      send_pair(point_pair(0, 0, 1023, 0, 0, 0));
      send_pair(point_pair(682, 341, 0, 341, 682, 0));
      send_pair(point_pair(1, 2, 0, 2, 1, 0));
      drain_pipeline();

      // zero counts act as one cell: saturate the sum
      set_grid(11'd0, 11'd0, 11'd0);
      send_pair(point_pair(0, 0, 0, 1023, 1023, 1023));
      send_pair(point_pair(0, 0, 0, 0, 0, 0));
      send_pair(point_pair(1, 0, 0, 0, 0, 0));
      drain_pipeline();

      // oversize counts clamp to the maximum
      set_grid(11'd2047, 11'd1025, 11'd3);
      send_pair(point_pair(0, 0, 0, 1023, 1023, 2));
      send_pair(point_pair(0, 0, 1, 0, 0, 2));
      send_pair(point_pair(1023, 0, 3, 0, 1023, 0));
      drain_pipeline();

      set_grid(11'd2, 11'd1, 11'd1024);
      send_pair(point_pair(0, 0, 0, 1, 0, 1023));
      send_pair(point_pair(1, 1, 512, 0, 0, 0));
      drain_pipeline();

      // random pairs under a range of cell count settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_grid(11'd1024, 11'd1024, 11'd1024);
            1: set_grid(11'd1, 11'd2, 11'd3);
            2: set_grid(11'd0, 11'd1025, 11'd2047);
            3: set_grid(CFG_W'($urandom_range(1, 1024)), CFG_W'($urandom_range(1, 1024)),
                        CFG_W'($urandom_range(1, 1024)));
            4: set_grid(11'd7, 11'd1000, 11'd513);
            5: set_grid(11'd2, 11'd1024, 11'd1);
            6: set_grid(CFG_W'($urandom_range(0, 2047)), CFG_W'($urandom_range(0, 2047)),
                        CFG_W'($urandom_range(0, 2047)));
            default: set_grid(11'd1024, 11'd1024, 11'd1);
         endcase
         run_random(PHASE_ITEMS);
      end

      if (error_count == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/gmid_pkg.sv
design/gmid_front.sv
design/gmid_sqrt_cell.sv
design/periodic_grid_min_image_distance.sv
tb/gmid_distance_monitor.sv
tb/tb_periodic_grid_min_image_distance.sv
